// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/brmq_pkg.sv
package brmq_pkg;
    localparam int MAX_LEN    = 16384;
    localparam int BLOCK_SIZE = 128;
    localparam int NUM_BLOCKS = (MAX_LEN + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int IDX_W      = $clog2(MAX_LEN);
    localparam int OFF_W      = $clog2(BLOCK_SIZE);
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int LEN_W      = 15;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    localparam logic [ADDR_W-1:0] ADDR_LEN_FIRST  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_LEN_SECOND = 3'd4;

    localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic                     mode;
        logic                     seq_select;
        logic [IDX_W-1:0]         first_index;
        logic [IDX_W-1:0]         last_index;
        logic signed [DATA_W-1:0] elem_value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] range_max;
        logic signed [DATA_W-1:0] range_min;
        logic                     status;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FOLD,
        ST_DONE
    } t_state;

    // one memory port access from the sequencer
    typedef struct packed {
        logic                     elem_rd;
        logic                     elem_wr;
        logic                     sum_rd;
        logic                     sum_wr;
        logic                     seq;
        logic [IDX_W-1:0]         elem_addr;
        logic [BLK_W-1:0]         sum_addr;
        logic signed [DATA_W-1:0] wdata;
        logic signed [DATA_W-1:0] smax;
        logic signed [DATA_W-1:0] smin;
    } t_mem_cmd;
endpackage

// File: hw/rtl/brmq_if.sv
interface brmq_req_if import brmq_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface brmq_rsp_if import brmq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/brmq_store.sv
module brmq_store import brmq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mem_cmd                 i_cmd,
    output logic signed [DATA_W-1:0] o_elem,
    output logic signed [DATA_W-1:0] o_smax,
    output logic signed [DATA_W-1:0] o_smin
);
    logic signed [DATA_W-1:0] r_vals0 [MAX_LEN];
    logic signed [DATA_W-1:0] r_vals1 [MAX_LEN];
    logic signed [DATA_W-1:0] r_max0 [NUM_BLOCKS];
    logic signed [DATA_W-1:0] r_min0 [NUM_BLOCKS];
    logic signed [DATA_W-1:0] r_max1 [NUM_BLOCKS];
    logic signed [DATA_W-1:0] r_min1 [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]    r_vld0;
    logic [NUM_BLOCKS-1:0]    r_vld1;
    logic signed [DATA_W-1:0] r_e0, r_e1, r_mx0, r_mn0, r_mx1, r_mn1;
    logic                     r_sel, r_v;

    always_ff @(posedge i_clk) begin
        if (i_cmd.elem_wr && !i_cmd.seq) r_vals0[i_cmd.elem_addr] <= i_cmd.wdata;
        if (i_cmd.elem_wr && i_cmd.seq) r_vals1[i_cmd.elem_addr] <= i_cmd.wdata;
        r_e0 <= r_vals0[i_cmd.elem_addr];
        r_e1 <= r_vals1[i_cmd.elem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_wr && !i_cmd.seq) begin
            r_max0[i_cmd.sum_addr] <= i_cmd.smax;
            r_min0[i_cmd.sum_addr] <= i_cmd.smin;
        end
        if (i_cmd.sum_wr && i_cmd.seq) begin
            r_max1[i_cmd.sum_addr] <= i_cmd.smax;
            r_min1[i_cmd.sum_addr] <= i_cmd.smin;
        end
        r_mx0 <= r_max0[i_cmd.sum_addr];
        r_mn0 <= r_min0[i_cmd.sum_addr];
        r_mx1 <= r_max1[i_cmd.sum_addr];
        r_mn1 <= r_min1[i_cmd.sum_addr];
        r_sel <= i_cmd.seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= '0;
            r_vld1 <= '0;
            r_v    <= 1'b0;
        end else begin
            if (i_cmd.sum_wr && !i_cmd.seq) r_vld0[i_cmd.sum_addr] <= 1'b1;
            if (i_cmd.sum_wr && i_cmd.seq) r_vld1[i_cmd.sum_addr] <= 1'b1;
            r_v <= i_cmd.seq ? r_vld1[i_cmd.sum_addr] : r_vld0[i_cmd.sum_addr];
        end
    end

    assign o_elem = r_sel ? r_e1 : r_e0;
    assign o_smax = !r_v ? MOST_NEG : (r_sel ? r_mx1 : r_mx0);
    assign o_smin = !r_v ? MOST_POS : (r_sel ? r_mn1 : r_mn0);
endmodule

// File: hw/rtl/brmq_seq.sv
module brmq_seq import brmq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [LEN_W-1:0]         i_len0,
    input  logic [LEN_W-1:0]         i_len1,
    brmq_req_if.sink                 req,
    brmq_rsp_if.source               rsp,
    output t_mem_cmd                 o_cmd,
    input  logic signed [DATA_W-1:0] i_elem,
    input  logic signed [DATA_W-1:0] i_smax,
    input  logic signed [DATA_W-1:0] i_smin
);
    t_state r_state, n_state;
    t_req   r_req;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [BLK_W-1:0] r_blk, n_blk;
    logic [1:0] r_phase, n_phase;
    logic r_pend, n_pend;
    logic r_pkind, n_pkind;
    logic signed [DATA_W-1:0] r_mx, r_mn, n_mx, n_mn;
    logic r_err, n_err;
    logic r_ov, n_ov;
    t_rsp r_out, n_out;

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] eff;
    logic [BLK_W-1:0] bl, br;
    logic last_elem;
    logic [IDX_W-1:0] left_end;

    assign len = req.data.seq_select ? i_len1 : i_len0;
    assign eff = (len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len;
    assign bl  = r_req.first_index[IDX_W-1:OFF_W];
    assign br  = r_req.last_index[IDX_W-1:OFF_W];
    assign left_end = {bl, {OFF_W{1'b1}}};

    always_comb begin
        n_state = r_state;
        n_ptr = r_ptr; n_blk = r_blk; n_phase = r_phase;
        n_pend = 1'b0; n_pkind = r_pkind;
        n_mx = r_mx; n_mn = r_mn;
        n_err = r_err;
        n_ov = r_ov; n_out = r_out;
        o_cmd = '0;
        o_cmd.seq = r_req.seq_select;
        last_elem = 1'b0;
        if (rsp.valid && rsp.ready) n_ov = 1'b0;
        // fold data read in previous cycle
        if (r_pend) begin
            if (!r_pkind) begin
                if (i_elem > n_mx) n_mx = i_elem;
                if (i_elem < n_mn) n_mn = i_elem;
            end else begin
                if (i_smax > n_mx) n_mx = i_smax;
                if (i_smin < n_mn) n_mn = i_smin;
            end
        end
        case (r_state)
            ST_IDLE: begin
                if (req.valid && req.ready) begin
                    n_mx = MOST_NEG; n_mn = MOST_POS;
                    n_err = 1'b0;
                    o_cmd.seq = req.data.seq_select;
                    if (!req.data.mode) begin
                        if ({1'b0, req.data.first_index} < eff) begin
                            o_cmd.sum_rd = 1'b1;
                            o_cmd.sum_addr = req.data.first_index[IDX_W-1:OFF_W];
                            n_state = ST_FOLD;
                        end
                    end else if (req.data.first_index > req.data.last_index ||
                                 {1'b0, req.data.last_index} >= eff) begin
                        n_mx = '0; n_mn = '0;
                        n_err = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_ptr = req.data.first_index;
                        n_phase = 2'd0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                case (r_phase)
                    2'd0: begin
                        o_cmd.elem_rd = 1'b1; o_cmd.elem_addr = r_ptr;
                        n_pend = 1'b1; n_pkind = 1'b0;
                        n_ptr = r_ptr + 1'b1;
                        if (bl == br) last_elem = (r_ptr == r_req.last_index);
                        else last_elem = (r_ptr == left_end);
                        if (last_elem) begin
                            if (bl == br) begin
                                n_phase = 2'd3;
                            end else begin
                                n_phase = 2'd1;
                                n_ptr = {br, {OFF_W{1'b0}}};
                            end
                        end
                    end
                    2'd1: begin
                        o_cmd.elem_rd = 1'b1; o_cmd.elem_addr = r_ptr;
                        n_pend = 1'b1; n_pkind = 1'b0;
                        n_ptr = r_ptr + 1'b1;
                        if (r_ptr == r_req.last_index) begin
                            n_blk = bl + 1'b1;
                            n_phase = (BLK_W'(bl + 1'b1) == br) ? 2'd3 : 2'd2;
                        end
                    end
                    2'd2: begin
                        o_cmd.sum_rd = 1'b1; o_cmd.sum_addr = r_blk;
                        n_pend = 1'b1; n_pkind = 1'b1;
                        n_blk = r_blk + 1'b1;
                        if (BLK_W'(r_blk + 1'b1) == br) n_phase = 2'd3;
                    end
                    default: begin
                        if (!r_pend) n_state = ST_DONE;
                    end
                endcase
            end
            ST_FOLD: begin
                o_cmd.sum_wr = 1'b1;
                o_cmd.elem_wr = 1'b1;
                o_cmd.elem_addr = r_req.first_index;
                o_cmd.sum_addr = bl;
                o_cmd.wdata = r_req.elem_value;
                o_cmd.smax = (r_req.elem_value > i_smax) ? r_req.elem_value : i_smax;
                o_cmd.smin = (r_req.elem_value < i_smin) ? r_req.elem_value : i_smin;
                n_state = ST_IDLE;
            end
            ST_DONE: begin
                if (!r_ov || (rsp.valid && rsp.ready)) begin
                    n_out = '{range_max: r_mx, range_min: r_mn, status: r_err};
                    n_ov = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign req.ready = (r_state == ST_IDLE);
    assign rsp.valid = r_ov;
    assign rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req.valid && req.ready) r_req <= req.data;
        r_ptr <= n_ptr; r_blk <= n_blk; r_phase <= n_phase; r_pkind <= n_pkind;
        r_mx <= n_mx; r_mn <= n_mn; r_err <= n_err; r_out <= n_out;
    end
endmodule

// File: hw/rtl/blocked_range_min_max_query_core.sv
// channel  dir  word
// req      in   mode, seq_select, first_index, last_index, elem_value
// rsp      out  range_max, range_min, status (queries only)
// Write: summary read, then write back; dropped if index >= length.
// Query: edge elements are read, then inner block summaries, one at a time
// through the single read port of the element and summary memories.
// Rejected query: status 1 with max and min 0.
// Reset is synchronous; summaries read as extremes until first written.
// A result stalled on rsp waits in the output register while the next word is
// taken; that word's result is held back until the register frees.
module blocked_range_min_max_query_core import brmq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    brmq_req_if.sink          req,
    brmq_rsp_if.source        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic [LEN_W-1:0] r_len0, r_len1;
    t_mem_cmd cmd;
    logic signed [DATA_W-1:0] elem, smax, smin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len0 <= LEN_W'(MAX_LEN);
            r_len1 <= LEN_W'(MAX_LEN);
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_LEN_FIRST) r_len0 <= pwdata[LEN_W-1:0];
            if (paddr == ADDR_LEN_SECOND) r_len1 <= pwdata[LEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    always_comb begin
        case (paddr)
            ADDR_LEN_FIRST:  prdata = 32'(r_len0);
            ADDR_LEN_SECOND: prdata = 32'(r_len1);
            default:         prdata = '0;
        endcase
    end

    brmq_seq u_seq (
        .i_clk, .i_rst_n, .i_len0(r_len0), .i_len1(r_len1), .req, .rsp,
        .o_cmd(cmd), .i_elem(elem), .i_smax(smax), .i_smin(smin)
    );

    brmq_store u_store (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_elem(elem), .o_smax(smax), .o_smin(smin)
    );
endmodule

// File: hw/rtl/brmq_checker.sv
`include "assert_macros.svh"

module brmq_checker import brmq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_status,
    input logic signed [DATA_W-1:0] rsp_max,
    input logic signed [DATA_W-1:0] rsp_min
);
    `ASSERT_IMPLIES(a_err_zero, i_clk, i_rst_n, rsp_valid && rsp_status, rsp_max == 0 && rsp_min == 0)
    `ASSERT_IMPLIES(a_order, i_clk, i_rst_n, rsp_valid && !rsp_status, rsp_max >= rsp_min)
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_max))
endmodule

bind blocked_range_min_max_query_core brmq_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.data.status), .rsp_max(rsp.data.range_max),
    .rsp_min(rsp.data.range_min)
);
